// ===== sv/line_sensor_position_tracker_unit_macros.svh =====
// Assertion macros shared by the line sensor tracker RTL.
// Included inside module bodies; relies on nothing but the clock and reset named in the call.
`ifndef LINE_SENSOR_POSITION_TRACKER_UNIT_MACROS_SVH
`define LINE_SENSOR_POSITION_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lspt_pkg.sv =====
// Types and codes of the line sensor position tracker.
// No dependencies; used by the interface users and the top level.
`default_nettype none

package lspt_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_TICK       = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_SOFT_RESET = 2'd3
    } lspt_op_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2,
        SIDE_BAD   = 2'd3
    } lspt_side_t;

    typedef enum logic [1:0] {
        REG_LOCATION_TABLE = 2'd0,
        REG_RELATIVE_TABLE = 2'd1,
        REG_STUCK_LIMIT    = 2'd2,
        REG_UNUSED         = 2'd3
    } lspt_reg_t;

    localparam int unsigned SENSOR_COUNT  = 8;
    localparam int unsigned START_BITS    = 6;
    localparam int unsigned MAX_JUMP      = 2;
    localparam logic [7:0]  PRIOR_RESET   = 8'h81;
    localparam logic [15:0] LIMIT_RESET   = 16'd100;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] raw_pins;
    } lspt_in_t;

    typedef struct packed {
        logic signed [7:0] location;
        logic [7:0]        rel_position;
        logic [1:0]        direction;
        logic [1:0]        last_side;
        logic              at_edge;
        logic              at_start_line;
        logic              stuck;
    } lspt_out_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [63:0] data;
    } lspt_cfg_t;

endpackage

`default_nettype wire

// ===== sv/lspt_stream_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from lspt_pkg at the point of instantiation.
`default_nettype none

interface lspt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/line_sensor_position_tracker_unit.sv =====
// Line sensor position tracker: one result request for every input request.
// The result is registered in the main result register, or in the skid register while the main one is held.
// Throughput: one request per cycle while the skid register is empty, set by the single state update path;
// a two-entry output stage (result register plus skid) decouples the sides.
// Reset (rst_n low, asynchronous): tables clear, stuck limit 100, tracking state cleared but prior sample 8'h81.
`default_nettype none

module line_sensor_position_tracker_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lspt_stream_if.sink   in_ch,
    lspt_stream_if.source out_ch,
    lspt_stream_if.sink   cfg_ch
);
    import lspt_pkg::*;

    // Configuration registers.
    logic [63:0] loc_table_reg;
    logic [63:0] rel_table_reg;
    logic [15:0] stuck_limit_reg;

    // Tracking state.
    logic [7:0]  latched_reg, latched_next;
    logic [7:0]  prior_reg, prior_next;
    logic [2:0]  prior_idx_reg, prior_idx_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  loc_reg, loc_next;
    logic [7:0]  rel_reg, rel_next;
    logic [1:0]  dir_reg, dir_next;
    logic [1:0]  side_reg, side_next;
    logic        start_reg, start_next;
    logic        edge_flag_reg, edge_flag_next;
    logic        stuck_reg, stuck_next;

    // Output stage: main result register and skid register.
    lspt_out_t   out_data_reg, skid_data_reg, result;
    logic        out_valid_reg, skid_valid_reg;

    lspt_in_t    req;
    logic        in_accept, out_fire;
    logic [7:0]  sample;
    logic [3:0]  sample_ones, latched_ones;
    logic [2:0]  low_idx;
    logic signed [3:0] jump;
    logic        jump_ok;
    logic [15:0] count_inc;

    assign req       = in_ch.data;
    // The input side stalls only when both output entries hold a result.
    assign in_ch.ready = !skid_valid_reg;
    assign in_accept = in_ch.valid && !skid_valid_reg;
    assign out_fire  = out_valid_reg && out_ch.ready;
    assign cfg_ch.ready = 1'b1;

    // Configuration is always accepted; an index past the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loc_table_reg   <= '0;
            rel_table_reg   <= '0;
            stuck_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.data.index)
                REG_LOCATION_TABLE: loc_table_reg   <= cfg_ch.data.data;
                REG_RELATIVE_TABLE: rel_table_reg   <= cfg_ch.data.data;
                REG_STUCK_LIMIT:    stuck_limit_reg <= cfg_ch.data.data[15:0];
                default:            ;
            endcase
        end
    end

    // Population counts and the position of the lowest lit sensor.
    always_comb
    begin
        sample       = ~req.raw_pins;
        sample_ones  = '0;
        latched_ones = '0;
        low_idx      = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            sample_ones  = sample_ones + {3'b000, sample[i]};
            latched_ones = latched_ones + {3'b000, latched_reg[i]};
        end
        for (int i = SENSOR_COUNT - 1; i >= 0; i--)
        begin
            if (latched_reg[i])
            begin
                low_idx = 3'(i);
            end
        end
    end

    // Positive jump means the lit sensor moved toward bit 0.
    assign jump      = $signed({1'b0, prior_idx_reg}) - $signed({1'b0, low_idx});
    assign jump_ok   = (jump <= $signed(4'(MAX_JUMP))) && (jump >= -$signed(4'(MAX_JUMP)));
    assign count_inc = count_reg + 16'd1;

    // Next tracking state for the request at the input.
    always_comb
    begin
        latched_next   = latched_reg;
        prior_next     = prior_reg;
        prior_idx_next = prior_idx_reg;
        count_next     = count_reg;
        loc_next       = loc_reg;
        rel_next       = rel_reg;
        dir_next       = dir_reg;
        side_next      = side_reg;
        start_next     = start_reg;
        edge_flag_next = edge_flag_reg;
        stuck_next     = stuck_reg;
        case (lspt_op_t'(req.operation))
            OP_SAMPLE:
            begin
                // An all-dark sample leaves the latch and the start flag alone.
                if (sample != 8'h00)
                begin
                    latched_next = sample;
                    start_next   = (sample_ones >= 4'(START_BITS));
                end
            end
            OP_TICK:
            begin
                if (latched_reg == prior_reg)
                begin
                    if (count_inc > stuck_limit_reg)
                    begin
                        count_next = '0;
                        stuck_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    count_next = '0;
                    prior_next = latched_reg;
                    // Only a single lit sensor that moved a short way is trusted.
                    if (latched_ones == 4'd1 && jump_ok)
                    begin
                        prior_idx_next = low_idx;
                        loc_next       = loc_table_reg[8 * low_idx +: 8];
                        rel_next       = rel_table_reg[8 * low_idx +: 8];
                        if (jump < 0)
                        begin
                            dir_next = SIDE_LEFT;
                        end
                        else if (jump > 0)
                        begin
                            dir_next = SIDE_RIGHT;
                        end
                        else
                        begin
                            dir_next = SIDE_NONE;
                        end
                        edge_flag_next = (low_idx == 3'd0) || (low_idx == 3'(SENSOR_COUNT - 1));
                        side_next      = low_idx[2] ? SIDE_LEFT : SIDE_RIGHT;
                    end
                end
            end
            OP_CLEAR:
            begin
                start_next = 1'b0;
            end
            default:
            begin
                latched_next   = '0;
                prior_next     = PRIOR_RESET;
                prior_idx_next = '0;
                count_next     = '0;
                loc_next       = '0;
                rel_next       = '0;
                dir_next       = SIDE_NONE;
                side_next      = SIDE_NONE;
                start_next     = 1'b0;
                edge_flag_next = 1'b0;
                stuck_next     = 1'b0;
            end
        endcase
    end

    // The result reports the state as it stands after this request.
    always_comb
    begin
        result.location          = $signed(loc_next);
        result.rel_position      = rel_next;
        result.direction         = dir_next;
        result.last_side         = side_next;
        result.at_edge           = edge_flag_next;
        result.at_start_line     = start_next;
        result.stuck             = stuck_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= '0;
            prior_reg     <= PRIOR_RESET;
            prior_idx_reg <= '0;
            count_reg     <= '0;
            loc_reg       <= '0;
            rel_reg       <= '0;
            dir_reg       <= SIDE_NONE;
            side_reg      <= SIDE_NONE;
            start_reg     <= 1'b0;
            edge_flag_reg <= 1'b0;
            stuck_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            latched_reg   <= latched_next;
            prior_reg     <= prior_next;
            prior_idx_reg <= prior_idx_next;
            count_reg     <= count_next;
            loc_reg       <= loc_next;
            rel_reg       <= rel_next;
            dir_reg       <= dir_next;
            side_reg      <= side_next;
            start_reg     <= start_next;
            edge_flag_reg <= edge_flag_next;
            stuck_reg     <= stuck_next;
        end
    end

    // Output valid bits. A new result goes to the main register when it is free
    // or draining, otherwise to the skid register, which refills the main one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (!out_valid_reg || out_fire))
        begin
            out_data_reg <= result;
        end
        else if (in_accept)
        begin
            skid_data_reg <= result;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`include "line_sensor_position_tracker_unit_macros.svh"

    // The skid entry is only ever filled behind a waiting main entry.
    `LSPT_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full while main result empty")

    // Stuck stays set until a soft reset request is accepted.
    `LSPT_ASSERT_NEXT(a_stuck_sticky, clk, rst_n, stuck_reg && !(in_accept && req.operation == OP_SOFT_RESET), stuck_reg, "stuck flag dropped without soft reset")

    // Tracking state moves only on an accepted request.
    `LSPT_ASSERT_NEXT(a_state_holds, clk, rst_n, !in_accept, $stable(loc_reg) && $stable(count_reg) && $stable(latched_reg), "tracking state changed without a request")

endmodule

`default_nettype wire
